>>> design/imusfp_pkg.sv
// ----------------------------------------------------------------------------
// imusfp_pkg
// Shared types and constants of the inertial sensor serial frame parser.
// ----------------------------------------------------------------------------
package imusfp_pkg;

  localparam int unsigned FrameLen = 11;
  localparam int unsigned FillW    = 4;

  localparam logic [7:0] HdrByte   = 8'h55;
  localparam logic [7:0] TypeMask  = 8'h50;
  localparam logic [7:0] TypeAccel = 8'h51;
  localparam logic [7:0] TypeRate  = 8'h52;
  localparam logic [7:0] TypeAngle = 8'h53;
  localparam logic [7:0] TypeMag   = 8'h54;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2,
    KIND_MAG   = 2'd3
  } kind_t;

  // Decoded frame, ahead of scaling.
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic signed [15:0] w0;
    logic signed [15:0] w1;
    logic signed [15:0] w2;
  } frame_t;

  // Scaled result as it leaves the block.
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } result_t;

endpackage

>>> design/imusfp_window.sv
// ----------------------------------------------------------------------------
// imusfp_window
// Sliding byte window with fill count, frame check and word decode.
// ----------------------------------------------------------------------------
module imusfp_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  output imusfp_pkg::frame_t   frame
);
  import imusfp_pkg::*;

  // The newest byte always sits at the top; the frame is the last eleven bytes.
  logic [7:0]       shreg [FrameLen];
  logic [FillW-1:0] fill;
  logic [FillW-1:0] fill_next;
  logic [7:0]       win [FrameLen];
  logic [7:0]       sum_lo;
  logic [7:0]       sum_hi;
  logic [7:0]       sum;
  logic             full;
  logic             check_ok;
  logic             type_known;

  always_comb begin
    for (int i = 0; i < FrameLen - 1; i++) begin
      win[i] = shreg[i+1];
    end
    win[FrameLen-1] = rx_byte;
  end

  always_comb begin
    sum_lo = '0;
    sum_hi = '0;
    for (int i = 0; i < 5; i++) begin
      sum_lo = sum_lo + win[i];
      sum_hi = sum_hi + win[i+5];
    end
    sum = sum_lo + sum_hi;
  end

  assign full       = (fill == FillW'(FrameLen - 1));
  assign check_ok   = (win[0] == HdrByte) && ((win[1] & TypeMask) == TypeMask) &&
                      (sum == win[FrameLen-1]);
  assign type_known = (win[1] inside {[TypeAccel:TypeMag]});

  always_comb begin
    if (!full) begin
      fill_next = fill + FillW'(1);
    end else if (check_ok) begin
      fill_next = '0;
    end else begin
      fill_next = FillW'(FrameLen - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < FrameLen - 1; i++) begin
        shreg[i] <= shreg[i+1];
      end
      shreg[FrameLen-1] <= rx_byte;
    end
  end

  always_comb begin
    frame.valid = accept && full && check_ok && type_known;
    frame.kind  = kind_t'(win[1][1:0] - 2'd1);
    frame.w0    = {win[3], win[2]};
    frame.w1    = {win[5], win[4]};
    frame.w2    = {win[7], win[6]};
  end

endmodule

>>> design/imusfp_scale.sv
// ----------------------------------------------------------------------------
// imusfp_scale
// Scales the three decoded words to Q16.16 by the factor of the frame kind.
// ----------------------------------------------------------------------------
module imusfp_scale (
  input  imusfp_pkg::frame_t  frame,
  output imusfp_pkg::result_t res
);
  import imusfp_pkg::*;

  logic signed [31:0] factor;

  always_comb begin
    case (frame.kind)
      KIND_ACCEL: factor = 32'sd32;
      KIND_RATE:  factor = 32'sd4000;
      KIND_ANGLE: factor = 32'sd360;
      KIND_MAG:   factor = 32'sd65536;
      default:    factor = 32'sd0;
    endcase
  end

  // Every product fits in 32 bits, so the truncation is exact.
  always_comb begin
    res.kind = frame.kind;
    res.x    = 32'(32'(frame.w0) * factor);
    res.y    = 32'(32'(frame.w1) * factor);
    res.z    = 32'(32'(frame.w2) * factor);
  end

endmodule

>>> design/imusfp_out_buf.sv
// ----------------------------------------------------------------------------
// imusfp_out_buf
// Output register with one skid entry between the parser and the receiver.
// ----------------------------------------------------------------------------
module imusfp_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_valid,
  input  imusfp_pkg::result_t  res,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output imusfp_pkg::result_t  out_res
);
  import imusfp_pkg::*;

  logic    skid_valid;
  result_t skid_res;
  logic    out_fire;

  assign out_fire = out_valid && !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_fire) begin
      out_valid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_res <= skid_res;
      end
    end else if (!out_valid || out_fire) begin
      out_res <= res;
    end else begin
      skid_res <= res;
    end
  end

endmodule

>>> design/imu_serial_frame_parser_top.sv
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_top
// Parser for 11-byte inertial sensor frames arriving one byte at a time.
// ----------------------------------------------------------------------------
// One byte of the serial stream is a request on the input channel
// (in_valid, in_stall, rx_byte); it is taken at an edge with in_valid high
// and in_stall low. While in_stall is low, bytes are taken one per cycle.
// Each byte completes the last eleven bytes seen; a frame with a good
// header, type bits and checksum of a known type yields one request on the
// output channel (out_valid, out_stall, kind, axis_x/y/z) in Q16.16.
// The result is registered at the edge that takes the byte closing a frame:
// in the output register, or in the skid entry while a stalled result holds
// the output register. The frame check and scaling run combinationally
// between the byte window registers and the output register.
// A stalled result holds; a second result then goes to a skid entry and
// in_stall rises until the receiver drains it, so no result is lost.
// Reset empties the window and drops any result not yet delivered.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic signed [31:0] axis_x,
  output logic signed [31:0] axis_y,
  output logic signed [31:0] axis_z
);
  import imusfp_pkg::*;

  logic    accept;
  logic    buf_full;
  frame_t  frame;
  result_t res;
  result_t out_res;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  imusfp_window u_window (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .frame   (frame)
  );

  imusfp_scale u_scale (
    .frame (frame),
    .res   (res)
  );

  imusfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (frame.valid),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign kind   = 2'(out_res.kind);
  assign axis_x = out_res.x;
  assign axis_y = out_res.y;
  assign axis_z = out_res.z;

endmodule

>>> design/imusfp_checker.sv
// ----------------------------------------------------------------------------
// imusfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module imusfp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         kind,
  input logic signed [31:0] axis_x,
  input logic signed [31:0] axis_y,
  input logic signed [31:0] axis_z
);
  import imusfp_pkg::*;

  // Reset drops any pending result and releases the input.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or stall still active after reset");

  // The input only waits while a result is pending at the output.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(axis_x) &&
      $stable(axis_y) && $stable(axis_z))
    else $error("stalled result changed");

  // Acceleration is scaled by 32, so the low five bits are always clear.
  a_accel_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ACCEL |->
      axis_x[4:0] == 5'd0 && axis_y[4:0] == 5'd0 && axis_z[4:0] == 5'd0)
    else $error("acceleration result not a multiple of 32");

  // Magnetic field is the raw word in the integer half.
  a_mag_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_MAG |->
      axis_x[15:0] == 16'd0 && axis_y[15:0] == 16'd0 && axis_z[15:0] == 16'd0)
    else $error("magnetic result has a fractional part");

endmodule

bind imu_serial_frame_parser_top imusfp_checker u_imusfp_checker (.*);

>>> tb/imu_serial_frame_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_top_tb
// Self-checking bench for the 11-byte inertial sensor frame parser.
// Frames of every kind, rejected and foreign frames and loose bytes are fed
// in one byte per request. A byte-level predictor keeps its own window of the
// stream and queues each scaled reading that a good frame should yield; every
// result the block delivers is compared with the oldest queued reading.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser_top_tb;
  import imusfp_pkg::*;

  localparam int NoFault = -1;

  localparam logic signed [31:0] AccelScale = 32'sd32;
  localparam logic signed [31:0] RateScale  = 32'sd4000;
  localparam logic signed [31:0] AngleScale = 32'sd360;
  localparam logic signed [31:0] MagScale   = 32'sd65536;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte   = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         kind;
  logic signed [31:0] axis_x;
  logic signed [31:0] axis_y;
  logic signed [31:0] axis_z;

  // Predictor state: the last bytes seen and how many of them are held.
  logic [7:0]  window_data [0:FrameLen-1];
  int unsigned window_count = 0;
  result_t     expected_readings [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_len      = 0;
  int unsigned hold_left     = 0;
  bit          hold_req      = 1'b0;
  int unsigned mismatches    = 0;

  imu_serial_frame_parser_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .axis_x    (axis_x),
    .axis_y    (axis_y),
    .axis_z    (axis_z)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("imu_serial_frame_parser_top: mismatch");
    $finish;
  end

  function automatic logic signed [31:0] scale_word(input logic [7:0] hi, input logic [7:0] lo,
                                                    input logic signed [31:0] factor);
    logic signed [31:0] w;
    w = {{16{hi[7]}}, hi, lo};
    return w * factor;
  endfunction

  function automatic void track_rx_byte(input logic [7:0] b);
    logic [7:0]         csum;
    logic signed [31:0] factor;
    result_t            r;
    if (window_count >= FrameLen) window_count = 0;
    window_data[window_count] = b;
    window_count++;
    if (window_count < FrameLen) return;
    csum = 8'h00;
    for (int i = 0; i < 10; i++) csum += window_data[i];
    if (window_data[0] != HdrByte || (window_data[1] & TypeMask) != TypeMask ||
        csum != window_data[10]) begin
      // The oldest byte falls out and the window slides on by one.
      for (int i = 0; i < 10; i++) window_data[i] = window_data[i+1];
      window_count = 10;
      return;
    end
    window_count = 0;
    case (window_data[1])
      TypeAccel: begin r.kind = KIND_ACCEL; factor = AccelScale; end
      TypeRate:  begin r.kind = KIND_RATE;  factor = RateScale;  end
      TypeAngle: begin r.kind = KIND_ANGLE; factor = AngleScale; end
      TypeMag:   begin r.kind = KIND_MAG;   factor = MagScale;   end
      default: return;
    endcase
    r.x = scale_word(window_data[3], window_data[2], factor);
    r.y = scale_word(window_data[5], window_data[4], factor);
    r.z = scale_word(window_data[7], window_data[6], factor);
    expected_readings.push_back(r);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: ERROR %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) track_rx_byte(rx_byte);
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result delivered with no good frame behind it");
        end else begin
          want = expected_readings.pop_front();
          if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
          if (axis_x !== want.x)
            report_mismatch($sformatf("axis_x %0d, expected %0d", axis_x, want.x));
          if (axis_y !== want.y)
            report_mismatch($sformatf("axis_y %0d, expected %0d", axis_y, want.y));
          if (axis_z !== want.z)
            report_mismatch($sformatf("axis_z %0d, expected %0d", axis_z, want.z));
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off counted here once asked for.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = hold_len;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Builds a frame with a correct checksum, then spoils one byte if asked.
  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] w0,
                            input logic [15:0] w1, input logic [15:0] w2, input int bad_pos);
    logic [7:0]  f [0:FrameLen-1];
    logic [15:0] temperature;
    temperature = 16'($urandom);
    f[0] = HdrByte;
    f[1] = ftype;
    f[2] = w0[7:0];
    f[3] = w0[15:8];
    f[4] = w1[7:0];
    f[5] = w1[15:8];
    f[6] = w2[7:0];
    f[7] = w2[15:8];
    f[8] = temperature[7:0];
    f[9] = temperature[15:8];
    f[10] = 8'h00;
    for (int i = 0; i < 10; i++) f[10] += f[i];
    if (bad_pos >= 0) f[bad_pos] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < FrameLen; i++) send_byte(f[i]);
  endtask

  // The sender stops offering bytes until every expected reading has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic test_each_kind();
    send_frame(TypeAccel, 16'h8000, 16'h7FFF, 16'hFFFF, NoFault);
    send_frame(TypeRate,  16'h7FFF, 16'h8000, 16'h0001, NoFault);
    send_frame(TypeAngle, 16'hFFFF, 16'h0000, 16'h8000, NoFault);
    send_frame(TypeMag,   16'h8000, 16'hFFFF, 16'h7FFF, NoFault);
  endtask

  // Good frames of a foreign type empty the window but yield nothing; a good rate frame follows.
  task automatic test_other_types();
    send_frame(8'h50, 16'h1234, 16'h5678, 16'h9ABC, NoFault);
    send_frame(8'hFF, 16'h0000, 16'hFFFF, 16'h8000, NoFault);
    send_frame(TypeRate, 16'h0001, 16'hFFFE, 16'h4000, NoFault);
  endtask

  // Bad header, bad checksum and missing type bits, then resync on loose bytes.
  task automatic test_rejected_frames();
    send_frame(TypeAccel, 16'h0100, 16'h0200, 16'h0300, 0);
    send_frame(TypeAngle, 16'h00FF, 16'hFF00, 16'h0F0F, 10);
    send_frame(8'h41, 16'h1111, 16'h2222, 16'h3333, NoFault);
    send_frame(8'h10, 16'hAAAA, 16'h5555, 16'hFFFF, NoFault);
    repeat (5) send_byte(8'($urandom));
    send_frame(TypeMag, 16'h0000, 16'h0001, 16'hFFFF, NoFault);
  endtask

  task automatic test_random_stream(input int n_frames);
    int unsigned roll;
    logic [7:0]  ftype;
    repeat (n_frames) begin
      if ($urandom_range(0, 99) < 10) repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      roll = $urandom_range(0, 99);
      if (roll < 80) ftype = TypeAccel + 8'($urandom_range(0, 3));
      else if (roll < 90) ftype = TypeMask | 8'($urandom);
      else ftype = 8'($urandom);
      send_frame(ftype, 16'($urandom), 16'($urandom), 16'($urandom),
                 ($urandom_range(0, 99) < 12) ? int'($urandom_range(0, 10)) : NoFault);
    end
  endtask

  // The receiver holds off long enough for the output and skid entries to
  // fill, so that the block has to refuse further byte requests.
  task automatic test_output_backpressure();
    hold_len = 300;
    hold_req = 1'b1;
    repeat (6) send_frame(TypeAccel + 8'($urandom_range(0, 3)), 16'($urandom),
                          16'($urandom), 16'($urandom), NoFault);
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 56;
    test_each_kind();
    test_other_types();
    test_rejected_frames();
    test_random_stream(27);
    wait_drained();

    send_idle_pct = 56;
    recv_idle_pct = 11;
    test_random_stream(27);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_stream(27);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("imu_serial_frame_parser_top: match");
    end else begin
      $display("imu_serial_frame_parser_top: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
design/imusfp_pkg.sv
design/imusfp_window.sv
design/imusfp_scale.sv
design/imusfp_out_buf.sv
design/imu_serial_frame_parser_top.sv
design/imusfp_checker.sv
tb/imu_serial_frame_parser_top_tb.sv
